FILE: design/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared types and constants of the duration literal parser.
// ----------------------------------------------------------------------------
package dlp_pkg;

    localparam int MAX_LENGTH = 255;
    localparam logic [7:0] CNT_LIMIT = (MAX_LENGTH < 255) ? 8'(MAX_LENGTH) : 8'd255;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;

    typedef enum logic [3:0] {
        CL_DIGIT, CL_D, CL_H, CL_S, CL_M, CL_N, CL_U, CL_USCORE,
        CL_T, CL_I, CL_E, CL_HASH, CL_PLUS, CL_MINUS, CL_TERM, CL_OTHER
    } cls_t;

    typedef enum logic [2:0] {
        U_NS, U_US, U_MS, U_S, U_M, U_H, U_D, U_ONE
    } unit_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PLAIN, PH_T, PH_TI, PH_TIM, PH_TIME, PH_HASH,
        PH_ELEM, PH_AFTER, PH_MPEND, PH_NPEND, PH_UPEND
    } phase_t;

    typedef struct packed {
        logic       start;
        cls_t       cls;
        logic [3:0] digit;
    } item_t;

    function automatic logic [63:0] unit_factor(unit_t u);
        logic [63:0] f;
        begin
            case (u)
                U_NS:    f = 64'd1;
                U_US:    f = 64'd1000;
                U_MS:    f = 64'd1_000_000;
                U_S:     f = NS_PER_SEC;
                U_M:     f = 64'd60 * NS_PER_SEC;
                U_H:     f = 64'd60 * 64'd60 * NS_PER_SEC;
                U_D:     f = 64'd24 * 64'd60 * 64'd60 * NS_PER_SEC;
                default: f = 64'd1;
            endcase
            return f;
        end
    endfunction

endpackage

FILE: design/dlp_front.sv
// ----------------------------------------------------------------------------
// dlp_front
// Accepts input beats and classifies each character for the back end.
// ----------------------------------------------------------------------------
module dlp_front (
    input  logic [7:0]          character,
    input  logic                start_req,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                q_full,
    output logic                push,
    output dlp_pkg::item_t      push_item
);
    import dlp_pkg::*;

    logic [7:0] lc;

    // fold upper case letters onto lower case
    assign lc       = (character inside {[8'h41:8'h5A]}) ? character + 8'd32 : character;
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.start = start_req;
        push_item.digit = character[3:0];
        if (character inside {[8'h30:8'h39]})
        begin
            push_item.cls = CL_DIGIT;
        end
        else
        begin
            case (lc)
                "d":             push_item.cls = CL_D;
                "h":             push_item.cls = CL_H;
                "s":             push_item.cls = CL_S;
                "m":             push_item.cls = CL_M;
                "n":             push_item.cls = CL_N;
                "u":             push_item.cls = CL_U;
                "_":             push_item.cls = CL_USCORE;
                "t":             push_item.cls = CL_T;
                "i":             push_item.cls = CL_I;
                "e":             push_item.cls = CL_E;
                "#":             push_item.cls = CL_HASH;
                "+":             push_item.cls = CL_PLUS;
                "-":             push_item.cls = CL_MINUS;
                8'h00, ",", ")": push_item.cls = CL_TERM;
                default:         push_item.cls = CL_OTHER;
            endcase
        end
    end

endmodule

FILE: design/dlp_fifo.sv
// ----------------------------------------------------------------------------
// dlp_fifo
// Short queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module dlp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dlp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output dlp_pkg::item_t head_item
);
    import dlp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == (AW+1)'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: design/dlp_back.sv
// ----------------------------------------------------------------------------
// dlp_back
// Parser state machine, digit accumulator, element multiplier pipeline and
// result register.
// ----------------------------------------------------------------------------
module dlp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  dlp_pkg::item_t     head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] duration_ns,
    output logic [7:0]         consumed,
    output logic               failed
);
    import dlp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [63:0] run_reg, run_next;
    logic        seen_reg, seen_next;
    logic        neg_reg, neg_next;
    unit_t       last_reg, last_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [63:0] total_reg;

    // multiplier pipeline: partial products, then product
    logic        vp_reg, vq_reg;
    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg, pp2_reg;
    logic [63:0] prod_reg;

    logic        out_valid_reg;
    logic [63:0] out_dur_reg;
    logic [7:0]  out_cnt_reg;
    logic        out_fail_reg;

    logic        act, replay, hold, busy;
    logic        emit;
    logic [63:0] emit_dur;
    logic [7:0]  emit_cnt;
    logic        emit_fail;
    logic        launch;
    unit_t       launch_unit;
    logic [63:0] fac;
    logic        need_total;
    logic [67:0] wide;
    logic [63:0] cap;
    cls_t        cls;
    logic        start;

    assign cls   = head_item.cls;
    assign start = head_item.start;
    assign busy  = vp_reg || vq_reg;

    always_comb
    begin
        logic is_elem_cls;
        is_elem_cls = (cls == CL_DIGIT) || (cls == CL_D) || (cls == CL_H) ||
                      (cls == CL_S) || (cls == CL_M) || (cls == CL_N) ||
                      (cls == CL_U) || (cls == CL_USCORE);
        need_total = !start && !is_elem_cls &&
                     ((phase_reg == PH_ELEM) || (phase_reg == PH_AFTER));
    end

    always_comb
    begin
        phase_t ph;
        phase_next  = phase_reg;
        run_next    = run_reg;
        seen_next   = seen_reg;
        neg_next    = neg_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        emit        = 1'b0;
        emit_dur    = '0;
        emit_cnt    = '0;
        emit_fail   = 1'b0;
        launch      = 1'b0;
        launch_unit = U_NS;
        replay      = 1'b0;
        cap         = SAT_POS;
        wide        = '0;
        ph          = phase_reg;

        if (start)
        begin
            run_next  = '0;
            seen_next = 1'b0;
            neg_next  = 1'b0;
            last_next = U_NS;
            cnt_next  = '0;
            ph        = PH_PLAIN;
        end

        if (start && (cls == CL_T))
        begin
            cnt_next   = 8'd1;
            phase_next = PH_T;
        end
        else if (start && ((cls == CL_PLUS) || (cls == CL_MINUS)))
        begin
            neg_next   = (cls == CL_MINUS);
            cnt_next   = 8'd1;
            phase_next = PH_PLAIN;
        end
        else
        begin
            // collapse the element path into one decision
            if ((ph == PH_HASH) && ((cls == CL_PLUS) || (cls == CL_MINUS)))
            begin
                neg_next   = (cls == CL_MINUS);
                cnt_next   = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                phase_next = PH_ELEM;
            end
            else
            begin
                case (ph)
                    PH_PLAIN:
                    begin
                        if (cls == CL_DIGIT)
                        begin
                            cap  = neg_next ? SAT_NEG : SAT_POS;
                            wide = ({4'b0, run_next} << 3) + ({4'b0, run_next} << 1)
                                 + 68'(head_item.digit);
                            run_next  = (wide > {4'b0, cap}) ? cap : wide[63:0];
                            seen_next = 1'b1;
                            cnt_next  = (cnt_next < CNT_LIMIT) ? cnt_next + 8'd1 : cnt_next;
                            phase_next = PH_PLAIN;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            phase_next = PH_IDLE;
                            if (seen_next)
                            begin
                                emit_dur = neg_next ? (64'd0 - run_next) : run_next;
                                emit_cnt = cnt_next;
                            end
                        end
                    end
                    PH_T, PH_TI, PH_TIM, PH_TIME:
                    begin
                        cnt_next = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                        if ((ph == PH_T) && (cls == CL_I))
                            phase_next = PH_TI;
                        else if (((ph == PH_T) || (ph == PH_TIME)) && (cls == CL_HASH))
                            phase_next = PH_HASH;
                        else if ((ph == PH_TI) && (cls == CL_M))
                            phase_next = PH_TIM;
                        else if ((ph == PH_TIM) && (cls == CL_E))
                            phase_next = PH_TIME;
                        else
                        begin
                            emit       = 1'b1;
                            emit_fail  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HASH, PH_ELEM, PH_AFTER:
                    begin
                        if ((ph == PH_AFTER) && (cls == CL_TERM))
                        begin
                            emit       = 1'b1;
                            emit_dur   = total_reg;
                            emit_cnt   = cnt_reg;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            case (cls)
                                CL_DIGIT:
                                begin
                                    wide = ({4'b0, run_reg} << 3) + ({4'b0, run_reg} << 1)
                                         + 68'(head_item.digit);
                                    run_next  = (wide > {4'b0, SAT_POS}) ? SAT_POS : wide[63:0];
                                    seen_next = 1'b1;
                                    cnt_next  = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                                    phase_next = PH_ELEM;
                                end
                                CL_D, CL_H, CL_S, CL_USCORE:
                                begin
                                    cnt_next = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                                    launch   = 1'b1;
                                    case (cls)
                                        CL_D:    launch_unit = U_D;
                                        CL_H:    launch_unit = U_H;
                                        CL_S:    launch_unit = U_S;
                                        default: launch_unit = last_reg;
                                    endcase
                                end
                                CL_M, CL_N, CL_U:
                                begin
                                    cnt_next = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                                    case (cls)
                                        CL_M:    phase_next = PH_MPEND;
                                        CL_N:    phase_next = PH_NPEND;
                                        default: phase_next = PH_UPEND;
                                    endcase
                                end
                                default:
                                begin
                                    emit       = 1'b1;
                                    phase_next = PH_IDLE;
                                    if (seen_reg || (total_reg == '0))
                                        emit_fail = 1'b1;
                                    else
                                    begin
                                        emit_dur = total_reg;
                                        emit_cnt = cnt_reg;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_MPEND:
                    begin
                        launch = 1'b1;
                        if (cls == CL_S)
                        begin
                            cnt_next    = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                            launch_unit = U_MS;
                        end
                        else
                        begin
                            // close the minutes element, then rerun this beat
                            launch_unit = U_M;
                            replay      = 1'b1;
                        end
                    end
                    PH_NPEND, PH_UPEND:
                    begin
                        if (cls == CL_S)
                        begin
                            cnt_next    = (cnt_reg < CNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
                            launch      = 1'b1;
                            launch_unit = (ph == PH_NPEND) ? U_NS : U_US;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            emit_fail  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (launch)
        begin
            last_next  = launch_unit;
            run_next   = '0;
            seen_next  = 1'b0;
            phase_next = PH_AFTER;
        end
    end

    assign fac  = unit_factor(launch_unit);
    assign hold = (need_total && busy) || (emit && out_valid_reg && out_stall);
    assign act  = head_valid && !hold;
    assign pop  = act && !replay;

    always_ff @(posedge clk)
    begin
        pp0_reg  <= run_reg[31:0] * fac[31:0];
        pp1_reg  <= run_reg[63:32] * fac[31:0];
        pp2_reg  <= run_reg[31:0] * fac[63:32];
        prod_reg <= pp0_reg + {pp1_reg + pp2_reg, 32'b0};
        if (act && emit)
        begin
            out_dur_reg  <= emit_dur;
            out_cnt_reg  <= emit_cnt;
            out_fail_reg <= emit_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            run_reg       <= '0;
            seen_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            last_reg      <= U_NS;
            cnt_reg       <= '0;
            total_reg     <= '0;
            vp_reg        <= 1'b0;
            vq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (act)
            begin
                phase_reg <= phase_next;
                run_reg   <= run_next;
                seen_reg  <= seen_next;
                neg_reg   <= neg_next;
                last_reg  <= last_next;
                cnt_reg   <= cnt_next;
            end
            // drop products in flight on restart
            vp_reg <= act && launch;
            vq_reg <= vp_reg && !(act && start);
            if (act && start)
                total_reg <= '0;
            else if (vq_reg)
                total_reg <= total_reg + (neg_reg ? (64'd0 - prod_reg) : prod_reg);
            if (act && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duration_ns = out_dur_reg;
    assign consumed    = out_cnt_reg;
    assign failed      = out_fail_reg;

endmodule

FILE: design/duration_literal_parser.sv
// ----------------------------------------------------------------------------
// duration_literal_parser
// Parses T#/TIME# duration literals and plain decimal counts, one character
// per beat, into a signed nanosecond value.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, character, start_req | in
//  output  | out_valid, out_stall, duration_ns,       | out
//          | consumed, failed                         |
//
// One character per cycle is taken while the queue has room; a 4-entry queue
// separates the classifier from the parser. A literal's end waits for the
// element multiplier (two stages) to fold into the total, and a minutes unit
// closed by a non-s character closes that element and then reruns the character.
// Reset is asynchronous and clears all control state; no clearing pass.
// in_stall follows the queue's full flag; out_stall holds the result register.
module duration_literal_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    input  logic               start_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] duration_ns,
    output logic [7:0]         consumed,
    output logic               failed
);
    import dlp_pkg::*;

    logic  q_full, push, pop, head_valid;
    item_t push_item, head_item;

    dlp_front u_front (
        .character (character),
        .start_req (start_req),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    dlp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    dlp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duration_ns (duration_ns),
        .consumed    (consumed),
        .failed      (failed)
    );

endmodule
